// ----- rtl/adlf_pkg.sv -----
// ----------------------------------------------------------------------------
// adlf_pkg
// Shared types and constants of the adjacent duplicate line filter.
// ----------------------------------------------------------------------------
package adlf_pkg;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_PULL  = 2'd1,
		FUNC_FLUSH = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	localparam logic [1:0]  MODE_COUNT    = 2'd1;
	localparam logic [1:0]  MODE_REPEATED = 2'd2;

	localparam logic        REG_OUTPUT_MODE = 1'b0;
	localparam logic        REG_IGNORE_CASE = 1'b1;

	localparam logic [7:0]  CHAR_NL     = 8'd10;
	localparam logic [7:0]  CHAR_UPPER_A = 8'd65;
	localparam logic [7:0]  CHAR_UPPER_Z = 8'd90;
	localparam logic [7:0]  CASE_OFFSET = 8'd32;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	// per-item info carried from the issue stage to the output stage
	typedef struct packed {
		logic        pull_data;
		logic        pull_nl;
		logic        cmp;
		logic [7:0]  data_byte;
		logic [15:0] run_count;
		logic        run_ready;
		logic        push_refused;
		logic        line_trunc;
	} adlf_item_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
		if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
			return c + CASE_OFFSET;
		return c;
	endfunction

endpackage

// ----- rtl/adlf_ram.sv -----
// ----------------------------------------------------------------------------
// adlf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module adlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/adlf_ctrl.sv -----
// ----------------------------------------------------------------------------
// adlf_ctrl
// Line and run state, configuration registers and line store access issue.
// ----------------------------------------------------------------------------
module adlf_ctrl import adlf_pkg::*; #(
	parameter int MAX_LINE = 512,
	parameter int LW = $clog2(MAX_LINE + 1),
	parameter int AW = $clog2(2 * MAX_LINE)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [1:0]    cfg_data,
	input  logic          accept,
	input  func_t         func,
	input  logic [7:0]    data_byte,
	input  logic          mismatch_fwd,
	output logic          ignore_case,
	output adlf_item_t    info,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [7:0]    ram_wdata,
	output logic          ram_re,
	output logic [AW-1:0] ram_raddr
);

	localparam int IW = $clog2(MAX_LINE);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_LINE);

	logic [1:0]    mode_q;
	logic          ic_q;
	logic          bank_q, bank_d;
	logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, rp_q, rp_d;
	logic          still_q, still_d;
	logic [15:0]   cnt_q, cnt_d;
	logic          have_q, have_d;
	logic          pend_q, pend_d;
	logic          ovf_q, ovf_d;
	logic          wait_q, wait_d;
	logic          flush_q, flush_d;
	logic          strunc_q, strunc_d;
	logic          do_end, do_flush, do_close, same, drop;

	function automatic logic [AW-1:0] addr(input logic bank, input logic [IW-1:0] idx);
		return AW'(idx) + (bank ? AW'(MAX_LINE) : AW'(0));
	endfunction

	assign ignore_case = ic_q;

	always_comb begin
		bank_d   = bank_q;
		cur_d    = cur_q;
		prev_d   = prev_q;
		rp_d     = rp_q;
		still_d  = still_q && !mismatch_fwd;
		cnt_d    = cnt_q;
		have_d   = have_q;
		pend_d   = pend_q;
		ovf_d    = ovf_q;
		wait_d   = wait_q;
		flush_d  = flush_q;
		strunc_d = strunc_q;
		do_end   = 1'b0;
		do_flush = 1'b0;
		do_close = 1'b0;
		same     = 1'b0;
		drop     = 1'b0;
		info     = '0;
		info.data_byte = data_byte;
		ram_we    = 1'b0;
		ram_waddr = addr(bank_q, cur_q[IW-1:0]);
		ram_wdata = data_byte;
		ram_re    = 1'b0;
		ram_raddr = addr(!bank_q, cur_q[IW-1:0]);

		if (accept) begin
			case (func)
				FUNC_PUSH: begin
					if (pend_q) begin
						info.push_refused = 1'b1;
					end else if (data_byte == CHAR_NL) begin
						do_end = 1'b1;
					end else if (cur_q >= MAX_LEN) begin
						ovf_d = 1'b1;
					end else begin
						if (have_q) begin
							if (cur_q < prev_q) begin
								ram_re   = 1'b1;
								info.cmp = 1'b1;
							end else begin
								still_d = 1'b0;
							end
						end
						ram_we = 1'b1;
						cur_d  = cur_q + LW'(1);
					end
				end
				FUNC_FLUSH: begin
					if (pend_q) begin
						info.push_refused = 1'b1;
					end else begin
						do_end   = (cur_q != '0) || ovf_q;
						do_flush = 1'b1;
					end
				end
				FUNC_PULL: begin
					if (pend_q) begin
						if (rp_q < prev_q) begin
							ram_re         = 1'b1;
							ram_raddr      = addr(!bank_q, rp_q[IW-1:0]);
							info.pull_data = 1'b1;
							rp_d           = rp_q + LW'(1);
						end else begin
							info.pull_nl = 1'b1;
							pend_d       = 1'b0;
							rp_d         = '0;
							if (wait_q) begin
								wait_d   = 1'b0;
								bank_d   = !bank_q;
								prev_d   = cur_q;
								strunc_d = ovf_q;
								cnt_d    = 16'd1;
								have_d   = 1'b1;
								cur_d    = '0;
								still_d  = 1'b1;
								ovf_d    = 1'b0;
							end else begin
								have_d = 1'b0;
							end
							if (flush_q) begin
								flush_d  = 1'b0;
								do_close = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (do_end) begin
			same = have_d && still_d && (cur_d == prev_d);
			drop = (mode_q == MODE_REPEATED) && (cnt_d < 16'd2);
			if (same) begin
				if (cnt_d != COUNT_MAX)
					cnt_d = cnt_d + 16'd1;
				cur_d   = '0;
				still_d = 1'b1;
				ovf_d   = 1'b0;
			end else if (!have_d || drop) begin
				bank_d   = !bank_d;
				prev_d   = cur_d;
				strunc_d = ovf_d;
				cnt_d    = 16'd1;
				have_d   = 1'b1;
				cur_d    = '0;
				still_d  = 1'b1;
				ovf_d    = 1'b0;
			end else begin
				pend_d = 1'b1;
				wait_d = 1'b1;
				rp_d   = '0;
			end
		end

		if (do_flush) begin
			if (pend_d)
				flush_d = 1'b1;
			else
				do_close = 1'b1;
		end

		if (do_close && have_d) begin
			if ((mode_q == MODE_REPEATED) && (cnt_d < 16'd2)) begin
				have_d = 1'b0;
			end else begin
				pend_d = 1'b1;
				wait_d = 1'b0;
				rp_d   = '0;
			end
		end

		info.run_ready  = pend_d;
		info.run_count  = (pend_d && (mode_q == MODE_COUNT || mode_q == MODE_REPEATED))
			? cnt_d : 16'd0;
		info.line_trunc = ovf_d || (pend_d && strunc_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 2'd0;
			ic_q     <= 1'b0;
			bank_q   <= 1'b0;
			cur_q    <= '0;
			prev_q   <= '0;
			rp_q     <= '0;
			still_q  <= 1'b1;
			cnt_q    <= 16'd0;
			have_q   <= 1'b0;
			pend_q   <= 1'b0;
			ovf_q    <= 1'b0;
			wait_q   <= 1'b0;
			flush_q  <= 1'b0;
			strunc_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OUTPUT_MODE: mode_q <= cfg_data;
					REG_IGNORE_CASE: ic_q   <= cfg_data[0];
					default: begin
					end
				endcase
			end
			bank_q   <= bank_d;
			cur_q    <= cur_d;
			prev_q   <= prev_d;
			rp_q     <= rp_d;
			still_q  <= still_d;
			cnt_q    <= cnt_d;
			have_q   <= have_d;
			pend_q   <= pend_d;
			ovf_q    <= ovf_d;
			wait_q   <= wait_d;
			flush_q  <= flush_d;
			strunc_q <= strunc_d;
		end
	end

	// pushes write the active bank, reads target the other one
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("line store read and write collide");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !ram_we)
		else $error("line store written while a run waits");

	assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= MAX_LEN && prev_q <= MAX_LEN && rp_q <= prev_q)
		else $error("line length or read pointer out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(wait_q || flush_q) |-> pend_q)
		else $error("waiting line or flush without a pending run");

endmodule

// ----- rtl/adjacent_duplicate_line_filter.sv -----
// ----------------------------------------------------------------------------
// adjacent_duplicate_line_filter
// Collapses runs of equal adjacent text lines and offers each run for readout.
// ----------------------------------------------------------------------------
// One item enters per cycle, pushes, pulls and flushes alike, with no stall
// beyond output backpressure; each item yields one result, registered in
// the issue stage and then in the output stage. The rate is set by the single
// read port of the line store: a push reads the previous line's byte at its
// position while the pushed byte is written into the other bank, and a pull
// reads one stored byte, so every item needs at most one read and one write.
// The compare result of a push is forwarded into the end-of-line decision of
// the item that follows. The line store needs no clearing after reset.
module adjacent_duplicate_line_filter import adlf_pkg::*; #(
	parameter int MAX_LINE = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic [1:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_byte, run_count, run_ready, push_refused,
	                              // line_truncated, zero fill
	output logic        m_tlast,  // line_end
	output logic        m_tuser   // out_valid
);

	localparam int LW = $clog2(MAX_LINE + 1);
	localparam int AW = $clog2(2 * MAX_LINE);

	logic          accept, advance, mismatch, mismatch_fwd, ignore_case;
	adlf_item_t    info, info_s1;
	logic          valid_s1;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata, out_byte;
	logic          out_valid_q;
	logic [31:0]   tdata_q;
	logic          tlast_q, tuser_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	adlf_ctrl #(
		.MAX_LINE (MAX_LINE),
		.LW       (LW),
		.AW       (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.func         (func_t'(s_tuser)),
		.data_byte    (s_tdata),
		.mismatch_fwd (mismatch_fwd),
		.ignore_case  (ignore_case),
		.info         (info),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr)
	);

	adlf_ram #(
		.WIDTH (8),
		.DEPTH (2 * MAX_LINE)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign mismatch = info_s1.cmp &&
		(fold(ram_rdata, ignore_case) != fold(info_s1.data_byte, ignore_case));
	assign mismatch_fwd = valid_s1 && advance && mismatch;

	assign out_byte = info_s1.pull_data ? ram_rdata :
		(info_s1.pull_nl ? CHAR_NL : 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= accept;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			info_s1 <= info;
		if (advance && valid_s1) begin
			tdata_q <= {5'd0, info_s1.line_trunc, info_s1.push_refused,
				info_s1.run_ready, info_s1.run_count, out_byte};
			tlast_q <= info_s1.pull_nl;
			tuser_q <= info_s1.pull_data || info_s1.pull_nl;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;
	assign m_tuser  = tuser_q;

endmodule
